[hw/rtl/bbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the bracket balance checker
// Character codes, classified operation format and verdict reason codes.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;  // )
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;  // }

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_code_e;

  typedef struct packed {
    op_code_e   code;
    logic [1:0] kind;
    logic       last;
  } op_t;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_CLOSE_EMPTY = 3'd1;
  localparam logic [2:0] ERR_MISMATCH    = 3'd2;
  localparam logic [2:0] ERR_LEFT_OPEN   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

  localparam int unsigned OP_QUEUE_DEPTH = 4;

endpackage

[hw/rtl/bbc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front: character classifier and operation queue
// Decodes each byte into open/close/none plus bracket kind and queues it.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     char_code_i,
  input  logic           is_last_i,
  output logic           op_valid_o,
  output bbc_pkg::op_t   op_o,
  input  logic           op_ready_i
);

  localparam int unsigned PW = $clog2(bbc_pkg::OP_QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(bbc_pkg::OP_QUEUE_DEPTH + 1);

  bbc_pkg::op_t op_in;
  bbc_pkg::op_t queue_q [bbc_pkg::OP_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] fill_q, fill_d;
  logic enq, deq;

  always_comb begin
    op_in.code = bbc_pkg::OP_NONE;
    op_in.kind = bbc_pkg::KIND_PAREN;
    op_in.last = is_last_i;
    case (char_code_i)
      bbc_pkg::CHAR_OPEN_PAREN: begin
        op_in.code = bbc_pkg::OP_OPEN;
        op_in.kind = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CHAR_OPEN_SQUARE: begin
        op_in.code = bbc_pkg::OP_OPEN;
        op_in.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CHAR_OPEN_CURLY: begin
        op_in.code = bbc_pkg::OP_OPEN;
        op_in.kind = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CHAR_CLOSE_PAREN: begin
        op_in.code = bbc_pkg::OP_CLOSE;
        op_in.kind = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CHAR_CLOSE_SQUARE: begin
        op_in.code = bbc_pkg::OP_CLOSE;
        op_in.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CHAR_CLOSE_CURLY: begin
        op_in.code = bbc_pkg::OP_CLOSE;
        op_in.kind = bbc_pkg::KIND_CURLY;
      end
      default: begin
        op_in.code = bbc_pkg::OP_NONE;
      end
    endcase
  end

  assign full       = (fill_q == NW'(bbc_pkg::OP_QUEUE_DEPTH));
  assign op_valid_o = (fill_q != '0);
  assign op_o       = queue_q[rd_ptr_q];
  assign enq        = push && !full;
  assign deq        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + PW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (enq && !deq) begin
      fill_d = fill_q + NW'(1);
    end else if (deq && !enq) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

[hw/rtl/bbc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back: kind stack engine and verdict register
// Executes queued operations on the stack and holds one pending verdict.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  bbc_pkg::op_t   op_i,
  output logic           op_ready_o,
  output logic           empty,
  input  logic           pop,
  output logic           balanced_o,
  output logic [2:0]     fail_reason_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Top entry lives in top_q, the one below it in below_q; the memory holds
  // every entry except the top, at its own stack index.
  logic [1:0]    mem_q [STACK_DEPTH];
  logic [1:0]    top_q, top_d, below_q;
  logic [CW-1:0] cnt_q, cnt_d, cnt_m1, cnt_m3;
  logic [2:0]    err_q, err_d, reason;
  logic          out_valid_q, out_balanced_q;
  logic [2:0]    out_reason_q;
  logic          fire, push_en, pop_en, wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  assign op_ready_o = !(op_i.last && out_valid_q && !pop);
  assign fire       = op_valid_i && op_ready_o;

  assign cnt_m1  = cnt_q - CW'(1);
  assign cnt_m3  = cnt_q - CW'(3);
  assign wr_addr = cnt_m1[AW-1:0];
  assign rd_addr = cnt_m3[AW-1:0];
  assign wr_en   = push_en && (cnt_q != '0);

  always_comb begin
    err_d   = err_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    push_en = 1'b0;
    pop_en  = 1'b0;
    if (fire && (err_q == bbc_pkg::ERR_NONE)) begin
      case (op_i.code)
        bbc_pkg::OP_OPEN: begin
          if (cnt_q == CW'(STACK_DEPTH)) begin
            err_d = bbc_pkg::ERR_OVERFLOW;
          end else begin
            push_en = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            top_d   = op_i.kind;
          end
        end
        bbc_pkg::OP_CLOSE: begin
          if (cnt_q == '0) begin
            err_d = bbc_pkg::ERR_CLOSE_EMPTY;
          end else begin
            pop_en = 1'b1;
            cnt_d  = cnt_m1;
            top_d  = below_q;
            if (top_q != op_i.kind) begin
              err_d = bbc_pkg::ERR_MISMATCH;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (err_d != bbc_pkg::ERR_NONE) begin
      reason = err_d;
    end else if (cnt_d != '0) begin
      reason = bbc_pkg::ERR_LEFT_OPEN;
    end else begin
      reason = bbc_pkg::ERR_NONE;
    end
    if (fire && op_i.last) begin
      cnt_d = '0;
      err_d = bbc_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= bbc_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (fire && op_i.last) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (fire && op_i.last) begin
      out_balanced_q <= (reason == bbc_pkg::ERR_NONE);
      out_reason_q   <= reason;
    end
  end

  // Stack memory with registered read of the entry under the new top.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
    if (pop_en) begin
      below_q <= mem_q[rd_addr];
    end else if (push_en) begin
      below_q <= top_q;
    end
  end

  assign empty         = !out_valid_q;
  assign balanced_o    = out_balanced_q;
  assign fail_reason_o = out_reason_q;

endmodule

[hw/rtl/bracket_balance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming balanced bracket checker
// Checks nesting of (), [] and {} over a byte string, one verdict per string.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | push / full          | char_code_i[7:0], is_last_i
//  result  | empty / pop          | balanced_o, fail_reason_o[2:0]
//
//  One byte per cycle sustained while full is low; a string's verdict passes
//  the classifier queue, then the stack engine into the result register.
//  Each bracket byte pushes or pops the stack top; the top and next entry sit in
//  flops and the memory read of the entry beneath is registered ahead of need.
//  Reset clears queue pointers, stack count, latched error and result valid;
//  the stack memory is not cleared, as only written entries are ever read.
//  A pending result that is not popped stalls only a last byte in the queue;
//  new bytes keep entering until the four-entry queue fills.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic       balanced_o,
  output logic [2:0] fail_reason_o
);

  // Classified operation between front and back.
  logic         op_valid;
  logic         op_ready;
  bbc_pkg::op_t op;

  // Front: decode each byte and buffer it so the stack engine can stall alone.
  bbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .op_valid_o  (op_valid),
    .op_o        (op),
    .op_ready_i  (op_ready)
  );

  // Back: stack operations, first error latch, and the verdict register.
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_i          (op),
    .op_ready_o    (op_ready),
    .empty         (empty),
    .pop           (pop),
    .balanced_o    (balanced_o),
    .fail_reason_o (fail_reason_o)
  );

endmodule

[test/tb_bracket_balance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker: self-checking bench for the bracket checker
// Streams byte strings through the push/full side and checks every verdict
// popped from the empty/pop side against a cycle-free nesting predictor.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;

  localparam int STACK_DEPTH = 16;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] reason;
  } verdict_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code_i = 8'h00;
  logic       is_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       balanced_o;
  logic [2:0] fail_reason_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code_i),
    .is_last_i    (is_last_i),
    .empty        (empty),
    .pop          (pop),
    .balanced_o   (balanced_o),
    .fail_reason_o(fail_reason_o)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  char_req_t  char_q[$];      // bytes waiting to be driven
  verdict_t   verdict_q[$];   // predicted verdicts, oldest first
  logic [7:0] str_buf[$];     // string under construction

  // predictor copy of the nesting state
  bbc_pkg::kind_e kind_stk[STACK_DEPTH];
  int             nest_depth = 0;
  logic [2:0]     latched_err = bbc_pkg::ERR_NONE;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int strings_queued = 0;
  int verdicts_checked = 0;
  int reason_hits[8];

  char_req_t  accepted_req;
  char_req_t  next_req;
  verdict_t   want_v;

  // --------------------------------------------------------------------------
  // character helpers
  // --------------------------------------------------------------------------
  function automatic bit is_opener(logic [7:0] c);
    return c == bbc_pkg::CHAR_OPEN_PAREN || c == bbc_pkg::CHAR_OPEN_SQUARE ||
           c == bbc_pkg::CHAR_OPEN_CURLY;
  endfunction

  function automatic bit is_closer(logic [7:0] c);
    return c == bbc_pkg::CHAR_CLOSE_PAREN || c == bbc_pkg::CHAR_CLOSE_SQUARE ||
           c == bbc_pkg::CHAR_CLOSE_CURLY;
  endfunction

  // kind of a bracket byte, opening or closing; meaningless for other bytes
  function automatic bbc_pkg::kind_e bracket_kind(logic [7:0] c);
    if (c == bbc_pkg::CHAR_OPEN_PAREN || c == bbc_pkg::CHAR_CLOSE_PAREN)
      return bbc_pkg::KIND_PAREN;
    if (c == bbc_pkg::CHAR_OPEN_SQUARE || c == bbc_pkg::CHAR_CLOSE_SQUARE)
      return bbc_pkg::KIND_SQUARE;
    return bbc_pkg::KIND_CURLY;
  endfunction

  function automatic logic [7:0] open_char(bbc_pkg::kind_e k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CHAR_OPEN_PAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_OPEN_SQUARE;
      default:              return bbc_pkg::CHAR_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(bbc_pkg::kind_e k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CHAR_CLOSE_PAREN;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_CLOSE_SQUARE;
      default:              return bbc_pkg::CHAR_CLOSE_CURLY;
    endcase
  endfunction

  // any byte the checker must pass over
  function automatic logic [7:0] other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_opener(c) || is_closer(c));
    return c;
  endfunction

  function automatic bbc_pkg::kind_e rand_kind();
    return bbc_pkg::kind_e'($urandom_range(2));
  endfunction

  // --------------------------------------------------------------------------
  // nesting predictor: one accepted byte in, zero or one verdict out
  // --------------------------------------------------------------------------
  function automatic void nest_step(char_req_t r);
    bbc_pkg::kind_e k;
    logic [2:0]     why;
    verdict_t       v;
    k = bracket_kind(r.code);
    // once an error is latched the rest of the string is ignored
    if (latched_err == bbc_pkg::ERR_NONE) begin
      if (is_opener(r.code)) begin
        // full stack: flag overflow, byte is dropped
        if (nest_depth >= STACK_DEPTH) latched_err = bbc_pkg::ERR_OVERFLOW;
        else begin
          kind_stk[nest_depth] = k;
          nest_depth++;
        end
      end else if (is_closer(r.code)) begin
        if (nest_depth == 0) latched_err = bbc_pkg::ERR_CLOSE_EMPTY;
        else begin
          // pop first, then compare with what came off
          nest_depth--;
          if (kind_stk[nest_depth] != k) latched_err = bbc_pkg::ERR_MISMATCH;
        end
      end
    end
    // the last byte is folded in above before the verdict is formed
    if (r.last) begin
      why = latched_err;
      if (why == bbc_pkg::ERR_NONE && nest_depth != 0) why = bbc_pkg::ERR_LEFT_OPEN;
      v.balanced = (why == bbc_pkg::ERR_NONE);
      v.reason   = why;
      verdict_q.push_back(v);
      nest_depth  = 0;
      latched_err = bbc_pkg::ERR_NONE;
    end
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("tb: MISMATCH %s", msg);
    fail_count++;
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers the next queued byte, holds it while full is high
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      char_code_i <= 8'h00;
      is_last_i   <= 1'b0;
    end else begin
      if (push && !full) begin
        accepted_req.code = char_code_i;
        accepted_req.last = is_last_i;
        nest_step(accepted_req);
        bytes_sent++;
      end
      // a held request stays untouched, so push sees one assignment per edge
      if (!push || !full) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = char_q.pop_front();
          push        <= 1'b1;
          char_code_i <= next_req.code;
          is_last_i   <= next_req.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: pops verdicts with random back-pressure, checks each field
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        verdicts_checked++;
        reason_hits[fail_reason_o]++;
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("verdict with none pending: balanced=%0b reason=%0d",
                                 balanced_o, fail_reason_o));
        end else begin
          want_v = verdict_q.pop_front();
          if (balanced_o !== want_v.balanced || fail_reason_o !== want_v.reason)
            note_failure($sformatf("verdict %0d: expected balanced=%0b reason=%0d, got %0b/%0d",
                                   verdicts_checked, want_v.balanced, want_v.reason,
                                   balanced_o, fail_reason_o));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // string builders
  // --------------------------------------------------------------------------
  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // moves str_buf into the drive queue, marking the last byte; counts the
  // bytes queued
  task automatic flush_string(output int counted);
    int        i;
    char_req_t r;
    counted = 0;
    for (i = 0; i < str_buf.size(); i++) begin
      r.code = str_buf[i];
      r.last = (i == str_buf.size() - 1);
      char_q.push_back(r);
      counted++;
    end
    str_buf.delete();
    strings_queued++;
  endtask

  // properly nested run with scattered non-bracket bytes
  task automatic add_wellformed(input int steps, input int max_depth);
    bbc_pkg::kind_e open_k[$];
    bbc_pkg::kind_e k;
    int             i;
    for (i = 0; i < steps; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          if (open_k.size() < max_depth) begin
            k = rand_kind();
            open_k.push_back(k);
            str_buf.push_back(open_char(k));
          end
        end
        4, 5, 6, 7: begin
          if (open_k.size() > 0) str_buf.push_back(close_char(open_k.pop_back()));
        end
        default: str_buf.push_back(other_char());
      endcase
    end
    while (open_k.size() > 0) str_buf.push_back(close_char(open_k.pop_back()));
  endtask

  // one random string: mostly legal nesting, some deep, some broken, some noise
  task automatic gen_string(output int counted);
    bbc_pkg::kind_e open_k[$];
    bbc_pkg::kind_e k;
    int             flavor;
    int             n;
    int             i;
    int             spots[$];
    flavor = $urandom_range(99);
    if (flavor < 55) begin
      add_wellformed($urandom_range(1, 16), $urandom_range(1, 8));
    end else if (flavor < 65) begin
      // runs up to and just past the stack depth
      n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      for (i = 0; i < n; i++) begin
        k = rand_kind();
        open_k.push_back(k);
        str_buf.push_back(open_char(k));
      end
      while (open_k.size() > 0) str_buf.push_back(close_char(open_k.pop_back()));
    end else if (flavor < 82) begin
      add_wellformed($urandom_range(2, 12), 6);
      case ($urandom_range(2))
        0: str_buf.push_front(close_char(rand_kind()));   // close with nothing open
        1: str_buf.push_front(open_char(rand_kind()));    // never closed
        default: begin
          // swap one closing bracket for another kind
          for (i = 0; i < str_buf.size(); i++)
            if (is_closer(str_buf[i])) spots.push_back(i);
          if (spots.size() == 0) begin
            add_text("[)");
          end else begin
            i = spots[$urandom_range(spots.size() - 1)];
            k = bbc_pkg::kind_e'((int'(bracket_kind(str_buf[i])) + 1 + $urandom_range(1)) % 3);
            str_buf[i] = close_char(k);
          end
        end
      endcase
      // trailing junk, possibly brackets, after the fault
      if ($urandom_range(1)) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) str_buf.push_back(8'($urandom_range(255)));
      end
    end else begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(1)) str_buf.push_back($urandom_range(1) ? open_char(rand_kind())
                                                                    : close_char(rand_kind()));
        else str_buf.push_back(8'($urandom_range(255)));
      end
    end
    if (str_buf.size() == 0) str_buf.push_back(other_char());
    flush_string(counted);
  endtask

  task automatic fill_random(input int target);
    int total;
    int got;
    total = 0;
    while (total < target) begin
      gen_string(got);
      total += got;
    end
  endtask

  // waits until every queued byte is in and every verdict is out
  task automatic drain_verdicts();
    while (char_q.size() != 0 || push) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    int got;
    for (i = 0; i < 8; i++) reason_hits[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase A: sender idles a little, receiver stalls about half the time
    send_idle_pct = 18;
    recv_idle_pct = 51;

    // directed strings
    add_text("{[(");                 // all kinds nested, a null byte inside
    str_buf.push_back(8'h00);
    add_text(")]}");
    flush_string(got);
    add_text(")");                   // close on empty, rest ignored
    str_buf.push_back(8'hFF);
    add_text("(");
    flush_string(got);
    add_text("(]");                  // wrong closing kind
    flush_string(got);
    add_text("[{");                  // left open, last byte is an opener
    flush_string(got);
    for (i = 0; i < STACK_DEPTH; i++) str_buf.push_back(open_char(bbc_pkg::kind_e'(i % 3)));
    str_buf.push_back(bbc_pkg::CHAR_OPEN_CURLY);   // overflow on the last byte
    flush_string(got);
    str_buf.push_back(8'h00);        // lone non-bracket terminator
    flush_string(got);

    fill_random(600);
    drain_verdicts();

    // phase B: roles swapped
    send_idle_pct = 51;
    recv_idle_pct = 18;
    fill_random(600);
    drain_verdicts();

    // phase C: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(520);
    drain_verdicts();

    // give a stray verdict time to show up
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0)
      note_failure($sformatf("%0d verdicts never arrived", verdict_q.size()));

    $display("tb: %0d strings, %0d bytes, %0d verdicts checked",
             strings_queued, bytes_sent, verdicts_checked);
    $display("tb: ok %0d, close-empty %0d, mismatch %0d, left-open %0d, overflow %0d",
             reason_hits[bbc_pkg::ERR_NONE], reason_hits[bbc_pkg::ERR_CLOSE_EMPTY],
             reason_hits[bbc_pkg::ERR_MISMATCH], reason_hits[bbc_pkg::ERR_LEFT_OPEN],
             reason_hits[bbc_pkg::ERR_OVERFLOW]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
